FILE: sv/ptz_command_frame_encoder_macros.svh
// Assertion macros for the PTZ command frame encoder.
// Depends on a clk and an active-low rst_n in the module that expands them.
`ifndef PTZ_COMMAND_FRAME_ENCODER_MACROS_SVH
`define PTZ_COMMAND_FRAME_ENCODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PTZFE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ptz frame encoder: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define PTZFE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ptz frame encoder: next-cycle check failed");

`endif

FILE: sv/ptzfe_pkg.sv
// Shared types, codes and helpers for the PTZ command frame encoder.
// No dependencies; used by ptzfe_frame_gen and the top level.
package ptzfe_pkg;

    localparam int unsigned FuncWidth = 5;

    // Configuration register indexes
    localparam logic CFG_CAMERA_ADDRESS     = 1'b0;
    localparam logic CFG_DEFAULT_MOVE_SPEED = 1'b1;

    localparam logic [7:0] CameraAddressReset    = 8'd1;
    localparam logic [7:0] DefaultMoveSpeedReset = 8'd50;

    // Opcodes
    localparam logic [7:0] OP_NONE        = 8'h00;
    localparam logic [7:0] OP_MOVE        = 8'h18;
    localparam logic [7:0] OP_ZOOM        = 8'h24;
    localparam logic [7:0] OP_IRIS        = 8'h23;
    localparam logic [7:0] OP_FOCUS       = 8'h25;
    localparam logic [7:0] OP_SET_PRESET  = 8'h1D;
    localparam logic [7:0] OP_GOTO_PRESET = 8'h11;
    localparam logic [7:0] OP_PAN_STOP    = 8'h13;
    localparam logic [7:0] OP_TILT_STOP   = 8'h14;
    localparam logic [7:0] OP_MENU        = 8'h28;

    // Data bytes
    localparam logic [7:0] DIR_RIGHT      = 8'h00;
    localparam logic [7:0] DIR_LEFT       = 8'h01;
    localparam logic [7:0] DIR_UP         = 8'h02;
    localparam logic [7:0] DIR_DOWN       = 8'h03;
    localparam logic [7:0] SUB_ZOOM_WIDE  = 8'h00;
    localparam logic [7:0] SUB_ZOOM_TELE  = 8'h01;
    localparam logic [7:0] SUB_IRIS_OPEN  = 8'h02;
    localparam logic [7:0] SUB_IRIS_CLOSE = 8'h03;
    localparam logic [7:0] SUB_FOCUS_NEAR = 8'h00;
    localparam logic [7:0] SUB_FOCUS_FAR  = 8'h01;
    localparam logic [7:0] SUB_ZOOM_STOP  = 8'h04;
    localparam logic [7:0] SUB_IRIS_STOP  = 8'h05;
    localparam logic [7:0] SUB_FOCUS_STOP = 8'h04;
    localparam logic [7:0] MENU_UP        = 8'h00;
    localparam logic [7:0] MENU_DOWN      = 8'h01;
    localparam logic [7:0] MENU_LEFT      = 8'h02;
    localparam logic [7:0] MENU_RIGHT     = 8'h03;
    localparam logic [7:0] MENU_ENTER     = 8'h04;
    localparam logic [7:0] MENU_STOP      = 8'hff;
    localparam logic [7:0] DATA_ZERO      = 8'h00;
    localparam logic [7:0] FOCUS_SPEED    = 8'h01;

    // 15*p/100 == (p * 19665) >> 17 for every 8-bit p
    localparam logic [14:0] SpeedRecip = 15'd19665;
    localparam int unsigned SpeedShift = 17;

    typedef enum logic [FuncWidth-1:0] {
        FN_PAN_LEFT    = 5'd0,
        FN_PAN_RIGHT   = 5'd1,
        FN_TILT_UP     = 5'd2,
        FN_TILT_DOWN   = 5'd3,
        FN_LEFT_UP     = 5'd4,
        FN_LEFT_DOWN   = 5'd5,
        FN_RIGHT_UP    = 5'd6,
        FN_RIGHT_DOWN  = 5'd7,
        FN_ZOOM_WIDE   = 5'd8,
        FN_ZOOM_TELE   = 5'd9,
        FN_IRIS_OPEN   = 5'd10,
        FN_IRIS_CLOSE  = 5'd11,
        FN_FOCUS_NEAR  = 5'd12,
        FN_FOCUS_FAR   = 5'd13,
        FN_STOP        = 5'd14,
        FN_SET_PRESET  = 5'd15,
        FN_GOTO_PRESET = 5'd16,
        FN_MENU_UP     = 5'd17,
        FN_MENU_DOWN   = 5'd18,
        FN_MENU_LEFT   = 5'd19,
        FN_MENU_RIGHT  = 5'd20,
        FN_MENU_ENTER  = 5'd21,
        FN_MENU_STOP   = 5'd22,
        FN_NONE        = 5'd23
    } func_t;

    typedef struct packed {
        logic [7:0] op_code;
        logic [7:0] data_first;
        logic [7:0] data_second;
        logic [7:0] check_byte;
    } frame_t;

    typedef struct packed {
        logic zoom;
        logic iris;
        logic focus;
        logic pan;
        logic tilt;
        logic diag;
    } flags_t;

    typedef struct packed {
        logic   has_frame;
        logic   two_frames;
        frame_t first;
        frame_t second;
        flags_t flags;
    } decode_t;

    function automatic logic [7:0] move_speed(input logic [7:0] pct);
        logic [22:0] prod;
        prod = 23'(pct) * 23'(SpeedRecip);
        return {2'b00, prod[22:SpeedShift]};
    endfunction

    function automatic frame_t make_frame(input logic [7:0] addr, input logic [7:0] op,
                                          input logic [7:0] d0, input logic [7:0] d1);
        frame_t f;
        f.op_code     = op;
        f.data_first  = d0;
        f.data_second = d1;
        f.check_byte  = addr ^ op ^ d0 ^ d1;
        return f;
    endfunction

endpackage

FILE: sv/ptzfe_frame_gen.sv
// Command decode for the PTZ command frame encoder: one command to up to two frames.
// Depends on ptzfe_pkg.
module ptzfe_frame_gen
    import ptzfe_pkg::*;
(
    input  logic [FuncWidth-1:0] func,
    input  logic [7:0]           param,
    input  logic [7:0]           camera_address,
    input  logic [7:0]           default_move_speed,
    input  flags_t               flags,
    output decode_t              dec
);

    logic [7:0] spd;
    logic [7:0] a;

    assign a   = camera_address;
    assign spd = move_speed((param != 8'd0) ? param : default_move_speed);

    always_comb
    begin
        dec            = '0;
        dec.flags      = flags;
        dec.has_frame  = 1'b1;
        dec.two_frames = 1'b0;
        case (func_t'(func))
            FN_PAN_LEFT:
            begin
                dec.first     = make_frame(a, OP_MOVE, DIR_LEFT, spd);
                dec.flags.pan = 1'b1;
            end
            FN_PAN_RIGHT:
            begin
                dec.first     = make_frame(a, OP_MOVE, DIR_RIGHT, spd);
                dec.flags.pan = 1'b1;
            end
            FN_TILT_UP:
            begin
                dec.first      = make_frame(a, OP_MOVE, DIR_UP, spd);
                dec.flags.tilt = 1'b1;
            end
            FN_TILT_DOWN:
            begin
                dec.first      = make_frame(a, OP_MOVE, DIR_DOWN, spd);
                dec.flags.tilt = 1'b1;
            end
            FN_LEFT_UP:
            begin
                dec.first      = make_frame(a, OP_MOVE, DIR_LEFT, spd);
                dec.second     = make_frame(a, OP_MOVE, DIR_UP, spd);
                dec.two_frames = 1'b1;
                dec.flags.diag = 1'b1;
            end
            FN_LEFT_DOWN:
            begin
                dec.first      = make_frame(a, OP_MOVE, DIR_LEFT, spd);
                dec.second     = make_frame(a, OP_MOVE, DIR_DOWN, spd);
                dec.two_frames = 1'b1;
                dec.flags.diag = 1'b1;
            end
            FN_RIGHT_UP:
            begin
                dec.first      = make_frame(a, OP_MOVE, DIR_RIGHT, spd);
                dec.second     = make_frame(a, OP_MOVE, DIR_UP, spd);
                dec.two_frames = 1'b1;
                dec.flags.diag = 1'b1;
            end
            FN_RIGHT_DOWN:
            begin
                dec.first      = make_frame(a, OP_MOVE, DIR_RIGHT, spd);
                dec.second     = make_frame(a, OP_MOVE, DIR_DOWN, spd);
                dec.two_frames = 1'b1;
                dec.flags.diag = 1'b1;
            end
            FN_ZOOM_WIDE:
            begin
                dec.first      = make_frame(a, OP_ZOOM, SUB_ZOOM_WIDE, DATA_ZERO);
                dec.flags.zoom = 1'b1;
            end
            FN_ZOOM_TELE:
            begin
                dec.first      = make_frame(a, OP_ZOOM, SUB_ZOOM_TELE, DATA_ZERO);
                dec.flags.zoom = 1'b1;
            end
            FN_IRIS_OPEN:
            begin
                dec.first      = make_frame(a, OP_IRIS, SUB_IRIS_OPEN, DATA_ZERO);
                dec.flags.iris = 1'b1;
            end
            FN_IRIS_CLOSE:
            begin
                dec.first      = make_frame(a, OP_IRIS, SUB_IRIS_CLOSE, DATA_ZERO);
                dec.flags.iris = 1'b1;
            end
            FN_FOCUS_NEAR:
            begin
                dec.first       = make_frame(a, OP_FOCUS, SUB_FOCUS_NEAR, FOCUS_SPEED);
                dec.flags.focus = 1'b1;
            end
            FN_FOCUS_FAR:
            begin
                dec.first       = make_frame(a, OP_FOCUS, SUB_FOCUS_FAR, FOCUS_SPEED);
                dec.flags.focus = 1'b1;
            end
            FN_STOP:
            begin
                // Stop the highest-priority running motion
                if (flags.zoom)
                begin
                    dec.flags.zoom = 1'b0;
                    dec.first      = make_frame(a, OP_ZOOM, SUB_ZOOM_STOP, DATA_ZERO);
                end
                else if (flags.iris)
                begin
                    dec.flags.iris = 1'b0;
                    dec.first      = make_frame(a, OP_IRIS, SUB_IRIS_STOP, DATA_ZERO);
                end
                else if (flags.focus)
                begin
                    dec.flags.focus = 1'b0;
                    dec.first       = make_frame(a, OP_FOCUS, SUB_FOCUS_STOP, DATA_ZERO);
                end
                else if (flags.pan || (!flags.tilt && flags.diag))
                begin
                    dec.flags.pan = 1'b0;
                    dec.first     = make_frame(a, OP_PAN_STOP, DATA_ZERO, DATA_ZERO);
                    if (flags.diag)
                    begin
                        // Diagonal needs a tilt stop right behind the pan stop
                        dec.flags.diag = 1'b0;
                        dec.flags.tilt = 1'b0;
                        dec.second     = make_frame(a, OP_TILT_STOP, DATA_ZERO, DATA_ZERO);
                        dec.two_frames = 1'b1;
                    end
                end
                else if (flags.tilt)
                begin
                    dec.flags.tilt = 1'b0;
                    dec.first      = make_frame(a, OP_TILT_STOP, DATA_ZERO, DATA_ZERO);
                end
                else
                begin
                    dec.first = make_frame(a, OP_NONE, DATA_ZERO, DATA_ZERO);
                end
            end
            FN_SET_PRESET:  dec.first = make_frame(a, OP_SET_PRESET, DATA_ZERO, param);
            FN_GOTO_PRESET: dec.first = make_frame(a, OP_GOTO_PRESET, DATA_ZERO, param);
            FN_MENU_UP:     dec.first = make_frame(a, OP_MENU, MENU_UP, DATA_ZERO);
            FN_MENU_DOWN:   dec.first = make_frame(a, OP_MENU, MENU_DOWN, DATA_ZERO);
            FN_MENU_LEFT:   dec.first = make_frame(a, OP_MENU, MENU_LEFT, DATA_ZERO);
            FN_MENU_RIGHT:  dec.first = make_frame(a, OP_MENU, MENU_RIGHT, DATA_ZERO);
            FN_MENU_ENTER:  dec.first = make_frame(a, OP_MENU, MENU_ENTER, DATA_ZERO);
            FN_MENU_STOP:   dec.first = make_frame(a, OP_MENU, MENU_STOP, DATA_ZERO);
            default:        dec.has_frame = 1'b0;
        endcase
    end

endmodule

FILE: sv/ptz_command_frame_encoder.sv
// PTZ command frame encoder, top level: request register, decode, result register.
// Depends on ptzfe_pkg, ptzfe_frame_gen and ptz_command_frame_encoder_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_ready, func, param) takes one command request.
//   Output channel (out_valid/out_ready) returns the six-byte frames of each request
//   as frame_address, op_code, data_first, data_second, check_byte (the sender
//   byte is always zero and is not carried). last_frame marks the final frame
//   of a command; diagonal moves and a combined pan/tilt stop give two frames.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   camera_address (index 0) and default_move_speed (index 1); always ready.
//   Write config only while the block is empty.
// Path: an accepted command passes the request register, the decode and the
//   result register before its first frame is valid.
// Throughput: one single-frame command per cycle while out_ready holds; a two-frame
//   command holds back the next request while its two frames leave through one result register.
// Commands with no frame (func 23 and up) are dropped in the request register.
// Reset: motion flags clear, camera_address = 1, default_move_speed = 50,
//   both stages empty.
// Stall: a held result keeps the request register full, then in_ready drops.
`include "ptz_command_frame_encoder_macros.svh"

module ptz_command_frame_encoder
    import ptzfe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // command requests
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [FuncWidth-1:0] func,
    input  logic [7:0]           param,
    // frames
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           frame_address,
    output logic [7:0]           op_code,
    output logic [7:0]           data_first,
    output logic [7:0]           data_second,
    output logic [7:0]           check_byte,
    output logic                 last_frame,
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [7:0]           cfg_data
);

    // Configuration registers
    logic [7:0] camera_address_reg;
    logic [7:0] default_move_speed_reg;

    // Request register
    logic                 s1_valid_reg;
    logic [FuncWidth-1:0] s1_func_reg;
    logic [7:0]           s1_param_reg;

    // Motion flags
    flags_t flags_reg;

    // Result register: up to two frames of one command
    logic       res_valid_reg;
    logic       res_valid_next;
    logic       res_sel_reg;
    logic       res_sel_next;
    logic       res_two_reg;
    logic [7:0] res_addr_reg;
    frame_t     res_first_reg;
    frame_t     res_second_reg;

    decode_t dec;
    frame_t  cur;
    logic    res_free;
    logic    s1_advance;
    logic    load;
    logic    out_fire;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            camera_address_reg     <= CameraAddressReset;
            default_move_speed_reg <= DefaultMoveSpeedReset;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CAMERA_ADDRESS:     camera_address_reg     <= cfg_data;
                CFG_DEFAULT_MOVE_SPEED: default_move_speed_reg <= cfg_data;
                default:                camera_address_reg     <= camera_address_reg;
            endcase
        end
    end

    // Decode the held request against the current flags
    ptzfe_frame_gen u_frame_gen (
        .func               (s1_func_reg),
        .param              (s1_param_reg),
        .camera_address     (camera_address_reg),
        .default_move_speed (default_move_speed_reg),
        .flags              (flags_reg),
        .dec                (dec)
    );

    // The result register frees up when its last frame is taken
    assign out_fire   = out_valid && out_ready;
    assign res_free   = !res_valid_reg || (out_fire && last_frame);
    assign s1_advance = s1_valid_reg && res_free;
    assign load       = s1_advance && dec.has_frame;
    assign in_ready   = !s1_valid_reg || res_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_func_reg  <= func;
            s1_param_reg <= param;
        end
    end

    // Advance flags when the request leaves; frameless requests leave them as is
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else if (s1_advance)
        begin
            flags_reg <= dec.flags;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_sel_next   = res_sel_reg;
        if (load)
        begin
            res_valid_next = 1'b1;
            res_sel_next   = 1'b0;
        end
        else if (out_fire)
        begin
            if (last_frame)
            begin
                res_valid_next = 1'b0;
                res_sel_next   = 1'b0;
            end
            else
            begin
                // Move on to the second frame of the command
                res_sel_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            res_sel_reg   <= 1'b0;
            res_two_reg   <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            res_sel_reg   <= res_sel_next;
            if (load)
            begin
                res_two_reg <= dec.two_frames;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_addr_reg   <= camera_address_reg;
            res_first_reg  <= dec.first;
            res_second_reg <= dec.second;
        end
    end

    assign cur           = res_sel_reg ? res_second_reg : res_first_reg;
    assign out_valid     = res_valid_reg;
    assign frame_address = res_addr_reg;
    assign op_code       = cur.op_code;
    assign data_first    = cur.data_first;
    assign data_second   = cur.data_second;
    assign check_byte    = cur.check_byte;
    assign last_frame    = !res_two_reg || res_sel_reg;

    // The second frame is shown only for a two-frame command
    `PTZFE_ASSERT_NOW(a_sel_needs_two, res_valid_reg && res_sel_reg, res_two_reg)
    // A taken first frame of a pair is followed by its final frame
    `PTZFE_ASSERT_NEXT(a_pair_follows, out_fire && !last_frame, out_valid && last_frame)
    // A blocked request stays in the request register
    `PTZFE_ASSERT_NEXT(a_s1_holds, s1_valid_reg && !res_free, s1_valid_reg)

endmodule

FILE: tb/sv/ptz_frame_checker.sv
// Frame checker for the PTZ command frame encoder: watches the command, frame and
// configuration channels, predicts every frame and compares. Depends on ptzfe_pkg.
module ptz_frame_checker
    import ptzfe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [FuncWidth-1:0] func,
    input  logic [7:0]           param,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [7:0]           frame_address,
    input  logic [7:0]           op_code,
    input  logic [7:0]           data_first,
    input  logic [7:0]           data_second,
    input  logic [7:0]           check_byte,
    input  logic                 last_frame,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [7:0]           cfg_data,
    output int unsigned          mismatch_count,
    output int unsigned          frames_pending
);

    localparam logic [7:0] ResetAddress = 8'd1;
    localparam logic [7:0] ResetSpeed   = 8'd50;

    typedef struct packed {
        logic [7:0] address;
        logic [7:0] op;
        logic [7:0] first;
        logic [7:0] second;
        logic [7:0] check;
        logic       last;
    } frame_rec_t;

    frame_rec_t  expected_frames[$];
    logic [7:0]  camera_address;
    logic [7:0]  default_speed;
    flags_t      motion;
    int unsigned mismatches = 0;

    assign mismatch_count = mismatches;

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t frame mismatch: %s", $time, what);
    endtask

    task automatic compare_byte(input string name, input logic [7:0] got,
                                input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %02h expected %02h", name, got, want));
    endtask

    task automatic queue_frame(input logic [7:0] op, input logic [7:0] first,
                               input logic [7:0] second, input logic last);
        frame_rec_t f;
        f.address = camera_address;
        f.op      = op;
        f.first   = first;
        f.second  = second;
        f.check   = camera_address ^ op ^ first ^ second;
        f.last    = last;
        expected_frames.push_back(f);
    endtask

    // Work out the frames of one accepted command and advance the motion flags.
    task automatic predict_command(input logic [FuncWidth-1:0] code, input logic [7:0] value);
        int unsigned pct;
        logic [7:0]  speed;
        logic [7:0]  horiz;
        logic [7:0]  vert;
        pct   = (value != 8'd0) ? value : default_speed;
        speed = 8'((15 * pct) / 100);
        horiz = (code == FN_LEFT_UP || code == FN_LEFT_DOWN) ? DIR_LEFT : DIR_RIGHT;
        vert  = (code == FN_LEFT_UP || code == FN_RIGHT_UP) ? DIR_UP : DIR_DOWN;
        case (code)
            FN_PAN_LEFT:
            begin
                queue_frame(OP_MOVE, DIR_LEFT, speed, 1'b1);
                motion.pan = 1'b1;
            end
            FN_PAN_RIGHT:
            begin
                queue_frame(OP_MOVE, DIR_RIGHT, speed, 1'b1);
                motion.pan = 1'b1;
            end
            FN_TILT_UP:
            begin
                queue_frame(OP_MOVE, DIR_UP, speed, 1'b1);
                motion.tilt = 1'b1;
            end
            FN_TILT_DOWN:
            begin
                queue_frame(OP_MOVE, DIR_DOWN, speed, 1'b1);
                motion.tilt = 1'b1;
            end
            FN_LEFT_UP, FN_LEFT_DOWN, FN_RIGHT_UP, FN_RIGHT_DOWN:
            begin
                queue_frame(OP_MOVE, horiz, speed, 1'b0);
                queue_frame(OP_MOVE, vert, speed, 1'b1);
                motion.diag = 1'b1;
            end
            FN_ZOOM_WIDE:
            begin
                queue_frame(OP_ZOOM, SUB_ZOOM_WIDE, DATA_ZERO, 1'b1);
                motion.zoom = 1'b1;
            end
            FN_ZOOM_TELE:
            begin
                queue_frame(OP_ZOOM, SUB_ZOOM_TELE, DATA_ZERO, 1'b1);
                motion.zoom = 1'b1;
            end
            FN_IRIS_OPEN:
            begin
                queue_frame(OP_IRIS, SUB_IRIS_OPEN, DATA_ZERO, 1'b1);
                motion.iris = 1'b1;
            end
            FN_IRIS_CLOSE:
            begin
                queue_frame(OP_IRIS, SUB_IRIS_CLOSE, DATA_ZERO, 1'b1);
                motion.iris = 1'b1;
            end
            FN_FOCUS_NEAR:
            begin
                queue_frame(OP_FOCUS, SUB_FOCUS_NEAR, FOCUS_SPEED, 1'b1);
                motion.focus = 1'b1;
            end
            FN_FOCUS_FAR:
            begin
                queue_frame(OP_FOCUS, SUB_FOCUS_FAR, FOCUS_SPEED, 1'b1);
                motion.focus = 1'b1;
            end
            FN_STOP:
            begin
                if (motion.zoom)
                begin
                    motion.zoom = 1'b0;
                    queue_frame(OP_ZOOM, SUB_ZOOM_STOP, DATA_ZERO, 1'b1);
                end
                else if (motion.iris)
                begin
                    motion.iris = 1'b0;
                    queue_frame(OP_IRIS, SUB_IRIS_STOP, DATA_ZERO, 1'b1);
                end
                else if (motion.focus)
                begin
                    motion.focus = 1'b0;
                    queue_frame(OP_FOCUS, SUB_FOCUS_STOP, DATA_ZERO, 1'b1);
                end
                else if (motion.pan || (!motion.tilt && motion.diag))
                begin
                    motion.pan = 1'b0;
                    // a running diagonal also needs its tilt half stopped
                    if (motion.diag)
                    begin
                        motion.diag = 1'b0;
                        motion.tilt = 1'b0;
                        queue_frame(OP_PAN_STOP, DATA_ZERO, DATA_ZERO, 1'b0);
                        queue_frame(OP_TILT_STOP, DATA_ZERO, DATA_ZERO, 1'b1);
                    end
                    else
                    begin
                        queue_frame(OP_PAN_STOP, DATA_ZERO, DATA_ZERO, 1'b1);
                    end
                end
                else if (motion.tilt)
                begin
                    motion.tilt = 1'b0;
                    queue_frame(OP_TILT_STOP, DATA_ZERO, DATA_ZERO, 1'b1);
                end
                else
                begin
                    queue_frame(OP_NONE, DATA_ZERO, DATA_ZERO, 1'b1);
                end
            end
            FN_SET_PRESET:  queue_frame(OP_SET_PRESET, DATA_ZERO, value, 1'b1);
            FN_GOTO_PRESET: queue_frame(OP_GOTO_PRESET, DATA_ZERO, value, 1'b1);
            FN_MENU_UP:     queue_frame(OP_MENU, MENU_UP, DATA_ZERO, 1'b1);
            FN_MENU_DOWN:   queue_frame(OP_MENU, MENU_DOWN, DATA_ZERO, 1'b1);
            FN_MENU_LEFT:   queue_frame(OP_MENU, MENU_LEFT, DATA_ZERO, 1'b1);
            FN_MENU_RIGHT:  queue_frame(OP_MENU, MENU_RIGHT, DATA_ZERO, 1'b1);
            FN_MENU_ENTER:  queue_frame(OP_MENU, MENU_ENTER, DATA_ZERO, 1'b1);
            FN_MENU_STOP:   queue_frame(OP_MENU, MENU_STOP, DATA_ZERO, 1'b1);
            default:
            begin
            end
        endcase
    endtask

    task automatic compare_frame();
        frame_rec_t want;
        if (expected_frames.size() == 0)
        begin
            report_mismatch($sformatf("frame op %02h with nothing expected", op_code));
        end
        else
        begin
            want = expected_frames.pop_front();
            compare_byte("frame_address", frame_address, want.address);
            compare_byte("op_code", op_code, want.op);
            compare_byte("data_first", data_first, want.first);
            compare_byte("data_second", data_second, want.second);
            compare_byte("check_byte", check_byte, want.check);
            if (last_frame !== want.last)
                report_mismatch($sformatf("last_frame got %b expected %b",
                                          last_frame, want.last));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_frames.delete();
            camera_address = ResetAddress;
            default_speed  = ResetSpeed;
            motion         = '0;
            frames_pending <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
                compare_frame();
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_CAMERA_ADDRESS)
                    camera_address = cfg_data;
                else
                    default_speed = cfg_data;
            end
            if (in_valid && in_ready)
                predict_command(func, param);
            frames_pending <= expected_frames.size();
        end
    end

endmodule

FILE: tb/sv/testbench.sv
// Top of the PTZ command frame encoder testbench: clock, reset, command and
// configuration stimulus, frame back-pressure and the verdict.
// Depends on ptzfe_pkg, ptz_command_frame_encoder and ptz_frame_checker.
module testbench;
    import ptzfe_pkg::*;

    localparam int unsigned RandomPhases  = 8;
    localparam int unsigned PhaseCommands = 125;
    localparam int unsigned TimeoutCycles = 400000;
    localparam int unsigned ClockPeriod   = 20;

    // back-pressure patterns for the frame channel
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_ALTERNATE,
        RX_LONG_STALL
    } rx_pattern_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic [FuncWidth-1:0] func      = '0;
    logic [7:0]           param     = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [7:0]           frame_address;
    logic [7:0]           op_code;
    logic [7:0]           data_first;
    logic [7:0]           data_second;
    logic [7:0]           check_byte;
    logic                 last_frame;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic                 cfg_index = CFG_CAMERA_ADDRESS;
    logic [7:0]           cfg_data  = '0;

    int unsigned mismatch_count;
    int unsigned frames_pending;
    int unsigned burst_left = 0;

    rx_pattern_t rx_pattern = RX_OPEN;
    logic [15:0] rx_clock   = '0;

    ptz_command_frame_encoder dut (.*);

    ptz_frame_checker checker_inst (.*);

    always #(ClockPeriod / 2) clk = ~clk;

    // Frame receiver: switch pattern each time the low byte of rx_clock wraps, so that stalls land on
    // every phase of the two-frame commands, with open stretches in between.
    always @(posedge clk)
    begin
        rx_clock <= rx_clock + 16'd1;
        if (rx_clock[7:0] == 8'd0)
            rx_pattern <= rx_pattern_t'($urandom_range(0, 3));
        case (rx_pattern)
            RX_OPEN:      out_ready <= 1'b1;
            RX_RANDOM:    out_ready <= ($urandom_range(0, 3) != 0);
            RX_ALTERNATE: out_ready <= rx_clock[0];
            default:      out_ready <= (rx_clock[2:0] < 3'd3);
        endcase
    end

    // Send one command request. Open a new burst after a random gap when the
    // current one runs out; hold valid and payload until the request is taken.
    task automatic send_command(input logic [FuncWidth-1:0] code, input logic [7:0] value);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_valid <= 1'b1;
        func     <= code;
        param    <= value;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        burst_left--;
    endtask

    // Write both registers back to back; keep valid high across the two writes.
    task automatic configure(input logic [7:0] address, input logic [7:0] speed);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_CAMERA_ADDRESS;
        cfg_data  <= address;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_index <= CFG_DEFAULT_MOVE_SPEED;
        cfg_data  <= speed;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Drop valid and wait for every predicted frame to come out. The extra
    // cycles cover a no-frame request still sitting in the request register.
    task automatic drain();
        in_valid   <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (frames_pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        logic [FuncWidth-1:0] code;
        logic [7:0]           value;
        int unsigned          pick;
        int unsigned          taken;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, on the reset register values.
        // Stop with no motion flagged gives a frame with op code and data bytes all zero.
        send_command(FN_STOP, 8'h00);
        // Moves: zero param falls back to the default speed, 255 is the top.
        send_command(FN_PAN_LEFT, 8'h00);
        send_command(FN_PAN_RIGHT, 8'hFF);
        send_command(FN_TILT_UP, 8'h01);
        send_command(FN_TILT_DOWN, 8'd100);
        // Diagonals give a pan frame then a tilt frame.
        send_command(FN_LEFT_UP, 8'h07);
        send_command(FN_LEFT_DOWN, 8'h80);
        send_command(FN_RIGHT_UP, 8'h00);
        send_command(FN_RIGHT_DOWN, 8'hFE);
        send_command(FN_ZOOM_WIDE, 8'h00);
        send_command(FN_ZOOM_TELE, 8'hFF);
        send_command(FN_IRIS_OPEN, 8'h55);
        send_command(FN_IRIS_CLOSE, 8'hAA);
        send_command(FN_FOCUS_NEAR, 8'h01);
        send_command(FN_FOCUS_FAR, 8'h7F);
        // Walk the stop priority: zoom, iris, focus, then the combined
        // pan and tilt stop because a diagonal is running.
        repeat (4) send_command(FN_STOP, 8'($urandom));
        send_command(FN_SET_PRESET, 8'hFF);
        send_command(FN_GOTO_PRESET, 8'h00);
        for (int k = FN_MENU_UP; k <= FN_MENU_STOP; k++)
            send_command(FuncWidth'(k), 8'($urandom));
        // Requests that make no frame must leave the flags alone.
        send_command(FN_NONE, 8'hFF);
        send_command({FuncWidth{1'b1}}, 8'h00);
        drain();

        // Random part: one register setting per phase, extremes first.
        for (int phase = 0; phase < RandomPhases; phase++)
        begin
            case (phase)
                0:       configure(8'hFF, 8'hFF);
                1:       configure(8'h00, 8'h00);
                2:       configure(8'h5A, 8'd100);
                default: configure(8'($urandom), 8'($urandom));
            endcase
            taken = 0;
            while (taken < PhaseCommands)
            begin
                // Mostly motions and stops so that the flags fill and drain;
                // a few no-frame requests as noise.
                pick = $urandom_range(0, 99);
                if (pick < 35)
                    code = FuncWidth'($urandom_range(FN_PAN_LEFT, FN_RIGHT_DOWN));
                else if (pick < 50)
                    code = FuncWidth'($urandom_range(FN_ZOOM_WIDE, FN_FOCUS_FAR));
                else if (pick < 78)
                    code = FN_STOP;
                else if (pick < 94)
                    code = FuncWidth'($urandom_range(FN_SET_PRESET, FN_MENU_STOP));
                else
                    code = FuncWidth'($urandom_range(FN_NONE, {FuncWidth{1'b1}}));
                case ($urandom_range(0, 7))
                    0, 1:    value = 8'h00;
                    2:       value = 8'hFF;
                    default: value = 8'($urandom);
                endcase
                send_command(code, value);
                if (code < FN_NONE)
                    taken++;
            end
            drain();
        end

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #(TimeoutCycles * ClockPeriod);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/ptzfe_pkg.sv
sv/ptzfe_frame_gen.sv
sv/ptz_command_frame_encoder.sv
tb/sv/ptz_frame_checker.sv
tb/sv/testbench.sv
